### rtl/core/evrd_pkg.sv
package evrd_pkg;

    localparam int GUARD_BITS = 16;
    localparam int WEIGHT_W   = 17;
    localparam int OUT_W      = 24;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [OUT_W-1:0]    OUT_MAX    = 24'hFFFFFF;
    localparam logic [CNT_W-1:0]    CNT_MAX    = 32'hFFFFFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 3'd3;

    localparam logic [WEIGHT_W-1:0] RST_SHORT_WEIGHT   = 17'd6554;
    localparam logic [WEIGHT_W-1:0] RST_LONG_WEIGHT    = 17'd655;
    localparam logic [15:0]         RST_WARMUP_SAMPLES = 16'd20;
    localparam logic [OUT_W-1:0]    RST_JUMP_THRESHOLD = 24'd32768;

endpackage

### rtl/core/evrd_smul.sv
// Shift-and-add multiplier: signed A times unsigned B, one bit of B per cycle.
module evrd_smul #(
    parameter int A_W = 41,
    parameter int B_W = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [A_W-1:0]      i_a,
    input  logic        [B_W-1:0]      i_b,
    output logic                       o_done,
    output logic signed [A_W+B_W-1:0]  o_prod
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic signed [P_W-1:0] r_a;
    logic signed [P_W-1:0] r_acc;
    logic [B_W-1:0]        r_b;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= P_W'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= CNT_W'(B_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/core/evrd_sqrt.sv
// Restoring floor square root, one root bit per cycle.
module evrd_sqrt #(
    parameter int R_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2*R_W-1:0] i_rad,
    output logic             o_done,
    output logic [R_W-1:0]   o_root
);
    localparam int CNT_W = $clog2(R_W + 1);

    logic [2*R_W-1:0] r_rad;
    logic [R_W+1:0]   r_rem;
    logic [R_W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [R_W+3:0] rem_sh;
    logic [R_W+3:0] trial;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_rad[2*R_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(R_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (ge) begin
                    r_rem  <= (R_W+2)'(rem_sh - trial);
                    r_root <= {r_root[R_W-2:0], 1'b1};
                end else begin
                    r_rem  <= (R_W+2)'(rem_sh);
                    r_root <= {r_root[R_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### rtl/core/evrd_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
module evrd_div #(
    parameter int N_W = 40,
    parameter int D_W = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_den;
    logic [D_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0] rem_sh;
    logic         ge;

    always_comb begin
        rem_sh = {r_rem, r_num[N_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(N_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // dividend shifts out at the top, quotient shifts in at the bottom
                r_num <= {r_num[N_W-2:0], ge};
                r_rem <= ge ? D_W'(rem_sh - {1'b0, r_den}) : D_W'(rem_sh);
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

### rtl/core/ewma_volatility_ratio_detector.sv
// EWMA volatility ratio detector. One signed Q8.16 sample per transaction
// yields one result: short and long volatility (floor square roots of two
// exponentially weighted variances of the deviation from an exponential
// mean), their ratio in Q8.16 (1.0 when long volatility is zero), a regime
// change flag and saturating counters. Work on a sample is serial: the mean
// update, the squared deviation and the two variance updates (the latter in
// parallel) each run in a shift-add multiplier, then the two square roots run
// in parallel and then the ratio divider; each unit is started by a
// registered strobe and hands back a registered done flag. With long
// volatility zero the divider is skipped. A new sample is taken as soon as
// the previous result sits in the output register, even while that result is
// still stalled; a stalled result only holds the block in its last step.
// Configuration is written through a plain write port; write it only while
// the block is idle, the block itself does not enforce this.
module ewma_volatility_ratio_detector
    import evrd_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_W-1:0]        o_fast_sigma,
    output logic [OUT_W-1:0]        o_slow_sigma,
    output logic [OUT_W-1:0]        o_sigma_ratio,
    output logic                    o_regime_changed,
    output logic [OUT_W-1:0]        o_prior_ratio,
    output logic [CNT_W-1:0]        o_change_count,
    output logic [CNT_W-1:0]        o_sample_count
);
    localparam int SB    = SAMPLE_BITS;
    localparam int XS_W  = SB + GUARD_BITS;
    localparam int MA_W  = XS_W + 1;
    localparam int MP_W  = MA_W + WEIGHT_W;
    localparam int MAG_W = SB + 1;
    localparam int SP_W  = 2 * MAG_W + 1;
    localparam int V_W   = 2 * SB;
    localparam int VA_W  = V_W + 1;
    localparam int VP_W  = VA_W + WEIGHT_W;
    localparam int Q_W   = SB + FRAC_BITS;
    localparam int SAT_W = (Q_W > OUT_W) ? Q_W : OUT_W;
    localparam int RT_W  = (SB > OUT_W) ? SB : OUT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MEAN, S_DEV, S_SQ, S_VAR, S_ROOT, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic [WEIGHT_W-1:0] r_ws, r_wl;
    logic [15:0]         r_warmup;
    logic [OUT_W-1:0]    r_thresh;

    logic signed [XS_W-1:0] r_xs;
    logic signed [XS_W-1:0] r_mean;
    logic [V_W-1:0]         r_svar, r_lvar;
    logic [V_W-1:0]         r_sq;
    logic [Q_W-1:0]         r_ratio;
    logic [OUT_W-1:0]       r_prev_ratio;
    logic                   r_seeded;
    logic [CNT_W-1:0]       r_samples, r_changes;

    logic r_st_mean, r_st_sq, r_st_var, r_st_root, r_st_div;

    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_o_sv, r_o_lv, r_o_ratio, r_o_old;
    logic                   r_o_changed;
    logic [CNT_W-1:0]       r_o_changes, r_o_samples;

    // unit connections
    logic                   mean_done, sq_done, svar_done, lvar_done;
    logic                   sroot_done, lroot_done, div_done;
    logic signed [MA_W-1:0] mean_a;
    logic signed [MP_W-1:0] mean_prod;
    logic signed [MAG_W:0]  sq_a;
    logic signed [SP_W-1:0] sq_prod;
    logic signed [VA_W-1:0] svar_a, lvar_a;
    logic signed [VP_W-1:0] svar_prod, lvar_prod;
    logic [SB-1:0]          sroot, lroot;
    logic [Q_W-1:0]         quot;

    logic [WEIGHT_W-1:0]    ws_c, wl_c;
    logic signed [MP_W-1:0] mean_step;
    logic [XS_W-1:0]        mean_new;
    logic signed [XS_W:0]   dev_sum;
    logic signed [MAG_W-1:0] devq;
    logic [MAG_W-1:0]       mag;
    logic [V_W-1:0]         sq_sat;
    logic signed [VP_W-1:0] svar_step, lvar_step;
    logic [V_W-1:0]         svar_new, lvar_new;
    logic [SAT_W-1:0]       ratio_ext;
    logic [OUT_W-1:0]       ratio24;
    logic [RT_W-1:0]        sv_ext, lv_ext;
    logic [OUT_W-1:0]       sv24, lv24;
    logic [OUT_W-1:0]       jump;
    logic                   changed;
    logic                   out_free;

    always_comb begin
        ws_c = (r_ws > WEIGHT_ONE) ? WEIGHT_ONE : r_ws;
        wl_c = (r_wl > WEIGHT_ONE) ? WEIGHT_ONE : r_wl;

        // mean' = mean + round((xs - mean) * w / 2^16)
        mean_a    = MA_W'(r_xs) - MA_W'(r_mean);
        mean_step = (mean_prod + $signed(MP_W'(32768))) >>> GUARD_BITS;
        mean_new  = XS_W'(mean_step + MP_W'(r_mean));

        dev_sum = (XS_W+1)'(r_xs) - (XS_W+1)'(r_mean) + $signed((XS_W+1)'(32768));
        devq    = dev_sum[XS_W:GUARD_BITS];
        mag     = devq[MAG_W-1] ? MAG_W'(-devq) : MAG_W'(devq);
        sq_a    = $signed({1'b0, mag});

        sq_sat = (sq_prod[SP_W-1:V_W] != '0) ? '1 : sq_prod[V_W-1:0];

        svar_a    = $signed({1'b0, r_sq}) - $signed({1'b0, r_svar});
        lvar_a    = $signed({1'b0, r_sq}) - $signed({1'b0, r_lvar});
        svar_step = (svar_prod + $signed(VP_W'(32768))) >>> GUARD_BITS;
        lvar_step = (lvar_prod + $signed(VP_W'(32768))) >>> GUARD_BITS;
        svar_new  = V_W'(svar_step + $signed(VP_W'({1'b0, r_svar})));
        lvar_new  = V_W'(lvar_step + $signed(VP_W'({1'b0, r_lvar})));

        ratio_ext = SAT_W'(r_ratio);
        ratio24   = (ratio_ext > SAT_W'(OUT_MAX)) ? OUT_MAX : ratio_ext[OUT_W-1:0];
        sv_ext    = RT_W'(sroot);
        lv_ext    = RT_W'(lroot);
        sv24      = (sv_ext > RT_W'(OUT_MAX)) ? OUT_MAX : sv_ext[OUT_W-1:0];
        lv24      = (lv_ext > RT_W'(OUT_MAX)) ? OUT_MAX : lv_ext[OUT_W-1:0];

        jump    = (ratio24 >= r_prev_ratio) ? ratio24 - r_prev_ratio
                                            : r_prev_ratio - ratio24;
        changed = r_seeded && (r_samples >= CNT_W'(r_warmup)) && (jump > r_thresh);

        out_free = !r_out_valid || !i_out_stall;
    end

    evrd_smul #(.A_W(MA_W), .B_W(WEIGHT_W)) u_mean_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_mean),
        .i_a(mean_a), .i_b(ws_c), .o_done(mean_done), .o_prod(mean_prod)
    );

    evrd_smul #(.A_W(MAG_W+1), .B_W(MAG_W)) u_sq_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_sq),
        .i_a(sq_a), .i_b(mag), .o_done(sq_done), .o_prod(sq_prod)
    );

    evrd_smul #(.A_W(VA_W), .B_W(WEIGHT_W)) u_svar_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_var),
        .i_a(svar_a), .i_b(ws_c), .o_done(svar_done), .o_prod(svar_prod)
    );

    evrd_smul #(.A_W(VA_W), .B_W(WEIGHT_W)) u_lvar_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_var),
        .i_a(lvar_a), .i_b(wl_c), .o_done(lvar_done), .o_prod(lvar_prod)
    );

    evrd_sqrt #(.R_W(SB)) u_sroot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_root),
        .i_rad(r_svar), .o_done(sroot_done), .o_root(sroot)
    );

    evrd_sqrt #(.R_W(SB)) u_lroot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_root),
        .i_rad(r_lvar), .o_done(lroot_done), .o_root(lroot)
    );

    evrd_div #(.N_W(Q_W), .D_W(SB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_st_div),
        .i_num({sroot, FRAC_BITS'(0)}), .i_den(lroot),
        .o_done(div_done), .o_quot(quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ws         <= RST_SHORT_WEIGHT;
            r_wl         <= RST_LONG_WEIGHT;
            r_warmup     <= RST_WARMUP_SAMPLES;
            r_thresh     <= RST_JUMP_THRESHOLD;
            r_mean       <= '0;
            r_svar       <= '0;
            r_lvar       <= '0;
            r_prev_ratio <= '0;
            r_seeded     <= 1'b0;
            r_samples    <= '0;
            r_changes    <= '0;
            r_st_mean    <= 1'b0;
            r_st_sq      <= 1'b0;
            r_st_var     <= 1'b0;
            r_st_root    <= 1'b0;
            r_st_div     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_st_mean <= 1'b0;
            r_st_sq   <= 1'b0;
            r_st_var  <= 1'b0;
            r_st_root <= 1'b0;
            r_st_div  <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SHORT_WEIGHT:   r_ws     <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_LONG_WEIGHT:    r_wl     <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_WARMUP_SAMPLES: r_warmup <= i_cfg_data[15:0];
                    CFG_JUMP_THRESHOLD: r_thresh <= i_cfg_data[OUT_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_xs      <= {i_sample, GUARD_BITS'(0)};
                        r_st_mean <= 1'b1;
                        r_state   <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (mean_done) begin
                        r_mean  <= mean_new;
                        r_state <= S_DEV;
                    end
                end
                S_DEV: begin
                    r_st_sq <= 1'b1;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (sq_done) begin
                        r_sq     <= sq_sat;
                        r_st_var <= 1'b1;
                        r_state  <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (svar_done && lvar_done) begin
                        r_svar    <= svar_new;
                        r_lvar    <= lvar_new;
                        r_st_root <= 1'b1;
                        r_state   <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sroot_done && lroot_done) begin
                        if (lroot == '0) begin
                            r_ratio <= Q_W'(1) << FRAC_BITS;
                            r_state <= S_OUT;
                        end else begin
                            r_st_div <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ratio <= quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_sv      <= sv24;
                        r_o_lv      <= lv24;
                        r_o_ratio   <= ratio24;
                        r_o_changed <= changed;
                        r_o_old     <= r_seeded ? r_prev_ratio : '0;
                        r_o_samples <= (r_samples != CNT_MAX) ? r_samples + CNT_W'(1)
                                                              : r_samples;
                        if (changed && r_changes != CNT_MAX) begin
                            r_changes   <= r_changes + CNT_W'(1);
                            r_o_changes <= r_changes + CNT_W'(1);
                        end else begin
                            r_o_changes <= r_changes;
                        end
                        if (r_samples != CNT_MAX) begin
                            r_samples <= r_samples + CNT_W'(1);
                        end
                        r_prev_ratio <= ratio24;
                        r_seeded     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_fast_sigma     = r_o_sv;
    assign o_slow_sigma     = r_o_lv;
    assign o_sigma_ratio    = r_o_ratio;
    assign o_regime_changed = r_o_changed;
    assign o_prior_ratio    = r_o_old;
    assign o_change_count   = r_o_changes;
    assign o_sample_count   = r_o_samples;
endmodule

### rtl/core/evrd_checker.sv
module evrd_checker
    import evrd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [OUT_W-1:0] o_slow_sigma,
    input logic [OUT_W-1:0] o_sigma_ratio,
    input logic             o_regime_changed,
    input logic [CNT_W-1:0] o_change_count,
    input logic [CNT_W-1:0] o_sample_count
);
    localparam logic [OUT_W-1:0] RATIO_ONE =
        (FRAC_BITS >= OUT_W) ? OUT_MAX : OUT_W'(64'd1 << FRAC_BITS);

    // a stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sigma_ratio))
        else $error("stalled result changed");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_slow_sigma == '0) |-> o_sigma_ratio == RATIO_ONE)
        else $error("ratio not 1.0 with zero long volatility");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != '0) && (o_change_count <= o_sample_count))
        else $error("counter mismatch");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_regime_changed |-> o_change_count != '0)
        else $error("change flagged but not counted");
endmodule

bind ewma_volatility_ratio_detector evrd_checker #(.FRAC_BITS(FRAC_BITS)) u_evrd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_slow_sigma(o_slow_sigma),
    .o_sigma_ratio(o_sigma_ratio),
    .o_regime_changed(o_regime_changed),
    .o_change_count(o_change_count),
    .o_sample_count(o_sample_count)
);
